// File: hw/rtl/path_kind_classifier_macros.svh
// Assertion helpers for the path kind classifier.
`ifndef PATH_KIND_CLASSIFIER_MACROS_SVH
`define PATH_KIND_CLASSIFIER_MACROS_SVH

`ifndef SYNTHESIS
// Checked only out of reset.
`define PKC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define PKC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PKC_ASSERT(lbl, prop, msg)
`define PKC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: hw/rtl/pkc_pkg.sv
`timescale 1ns / 1ps

package pkc_pkg;

  typedef enum logic [1:0] {
    KIND_ABS = 2'd0,
    KIND_REL = 2'd1,
    KIND_UNK = 2'd2
  } kind_t;

  typedef enum logic [8:0] {
    PH_PREFIX        = 9'b000000001,
    PH_AFTER_ALPHA   = 9'b000000010,
    PH_AFTER_DOLLAR  = 9'b000000100,
    PH_AFTER_PERCENT = 9'b000001000,
    PH_MACRO_DOLLAR  = 9'b000010000,
    PH_MACRO_PERCENT = 9'b000100000,
    PH_BRACE         = 9'b001000000,
    PH_PCT_NAME      = 9'b010000000,
    PH_DONE          = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } item_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_DOT    = 8'h2e;

  localparam logic [3:0] FILE_LEN   = 4'd8;
  localparam logic [3:0] EXT_LEN    = 4'd9;
  localparam logic [3:0] NAME_SAT   = 4'd10;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? (c | 8'h20) : c;
  endfunction

  // "filename", lower case
  function automatic logic [7:0] file_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h66;
      3'd1:    ch = 8'h69;
      3'd2:    ch = 8'h6c;
      3'd3:    ch = 8'h65;
      3'd4:    ch = 8'h6e;
      3'd5:    ch = 8'h61;
      3'd6:    ch = 8'h6d;
      default: ch = 8'h65;
    endcase
    return ch;
  endfunction

  // "extension", lower case
  function automatic logic [7:0] ext_char(input logic [3:0] pos);
    logic [7:0] ch;
    unique case (pos)
      4'd0:    ch = 8'h65;
      4'd1:    ch = 8'h78;
      4'd2:    ch = 8'h74;
      4'd3:    ch = 8'h65;
      4'd4:    ch = 8'h6e;
      4'd5:    ch = 8'h73;
      4'd6:    ch = 8'h69;
      4'd7:    ch = 8'h6f;
      4'd8:    ch = 8'h6e;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic kind_t finish_kind(input phase_t ph, input kind_t k);
    kind_t r;
    if (ph == PH_DONE) r = k;
    else if (ph == PH_AFTER_DOLLAR) r = KIND_ABS;
    else r = KIND_REL;
    return r;
  endfunction

endpackage

// File: hw/rtl/pkc_parser.sv
`timescale 1ns / 1ps

module pkc_parser
  import pkc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  item_t item,
  output kind_t kind
);

  phase_t     phase_r, phase_nxt;
  kind_t      kind_r, kind_nxt;
  logic [3:0] len_r, len_nxt;
  logic       fmatch_r, fmatch_nxt;
  logic       ematch_r, ematch_nxt;
  logic       nvalid_r, nvalid_nxt;
  logic       ended_r, ended_nxt;

  logic [7:0] c;
  logic [7:0] lc;
  logic       macro_ok;
  logic       pct_ok;

  assign c        = item.char_code;
  assign lc       = to_lower(c);
  assign macro_ok = is_alpha(c) || is_digit(c) || (c == CH_UNDER) || (c == CH_DOT);
  assign pct_ok   = is_alpha(c) || is_digit(c) || (c == CH_UNDER);

  always_comb begin
    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    len_nxt    = len_r;
    fmatch_nxt = fmatch_r;
    ematch_nxt = ematch_r;
    nvalid_nxt = nvalid_r;
    ended_nxt  = ended_r;

    if (en && !ended_r) begin
      if (c == CH_NUL) begin
        kind_nxt  = finish_kind(phase_r, kind_r);
        phase_nxt = PH_DONE;
        ended_nxt = 1'b1;
      end else begin
        unique case (phase_r)
          PH_PREFIX: begin
            if (c == CH_QUOTE || c == CH_BANG) begin
              phase_nxt = PH_PREFIX;
            end else if (c == CH_SLASH || c == CH_BSLASH) begin
              kind_nxt  = KIND_ABS;
              phase_nxt = PH_DONE;
            end else if (is_alpha(c)) begin
              phase_nxt = PH_AFTER_ALPHA;
            end else if (c == CH_DOLLAR) begin
              phase_nxt = PH_AFTER_DOLLAR;
            end else if (c == CH_PCT) begin
              phase_nxt = PH_AFTER_PERCENT;
            end else begin
              kind_nxt  = KIND_REL;
              phase_nxt = PH_DONE;
            end
          end
          PH_AFTER_ALPHA: begin
            kind_nxt  = (c == CH_COLON) ? KIND_ABS : KIND_REL;
            phase_nxt = PH_DONE;
          end
          PH_AFTER_DOLLAR: begin
            if (c == CH_LPAREN) begin
              phase_nxt = PH_MACRO_DOLLAR;
            end else begin
              kind_nxt  = KIND_ABS;
              phase_nxt = PH_DONE;
            end
          end
          PH_AFTER_PERCENT: begin
            if (c == CH_LPAREN) begin
              phase_nxt = PH_MACRO_PERCENT;
            end else if (c == CH_LBRACE) begin
              phase_nxt = PH_BRACE;
            end else if (pct_ok) begin
              phase_nxt = PH_PCT_NAME;
            end else begin
              kind_nxt  = KIND_REL;
              phase_nxt = PH_DONE;
            end
          end
          PH_MACRO_DOLLAR, PH_MACRO_PERCENT: begin
            if (c == CH_RPAREN) begin
              phase_nxt = PH_DONE;
              if (phase_r == PH_MACRO_DOLLAR) begin
                kind_nxt = nvalid_r ? KIND_ABS : KIND_REL;
              end else if ((len_r == FILE_LEN && fmatch_r) ||
                           (len_r == EXT_LEN && ematch_r) || !nvalid_r) begin
                kind_nxt = KIND_REL;
              end else begin
                kind_nxt = KIND_ABS;
              end
            end else begin
              // accumulate one name character
              if (!macro_ok) nvalid_nxt = 1'b0;
              if (len_r >= FILE_LEN || lc != file_char(len_r[2:0])) fmatch_nxt = 1'b0;
              if (len_r >= EXT_LEN || lc != ext_char(len_r)) ematch_nxt = 1'b0;
              if (len_r < NAME_SAT) len_nxt = len_r + 4'd1;
            end
          end
          PH_BRACE: begin
            if (c == CH_RBRACE) begin
              kind_nxt  = KIND_UNK;
              phase_nxt = PH_DONE;
            end
          end
          PH_PCT_NAME: begin
            if (c == CH_PCT) begin
              kind_nxt  = KIND_ABS;
              phase_nxt = PH_DONE;
            end else if (!pct_ok) begin
              kind_nxt  = KIND_REL;
              phase_nxt = PH_DONE;
            end
          end
          PH_DONE: begin
            phase_nxt = PH_DONE;
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end

    kind = finish_kind(phase_nxt, kind_nxt);

    if (en && item.last_char) begin
      phase_nxt  = PH_PREFIX;
      kind_nxt   = KIND_REL;
      len_nxt    = '0;
      fmatch_nxt = 1'b1;
      ematch_nxt = 1'b1;
      nvalid_nxt = 1'b1;
      ended_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_PREFIX;
      kind_r   <= KIND_REL;
      len_r    <= '0;
      fmatch_r <= 1'b1;
      ematch_r <= 1'b1;
      nvalid_r <= 1'b1;
      ended_r  <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      kind_r   <= kind_nxt;
      len_r    <= len_nxt;
      fmatch_r <= fmatch_nxt;
      ematch_r <= ematch_nxt;
      nvalid_r <= nvalid_nxt;
      ended_r  <= ended_nxt;
    end
  end

endmodule

// File: hw/rtl/path_kind_classifier.sv
`timescale 1ns / 1ps
// Path kind classifier.
// in_*  : one path character per beat; in_tdata[7:0] is the character, in_tlast
//         marks the final character of a path. A zero byte ends the path early;
//         beats after it up to in_tlast are consumed and ignored.
// out_* : one beat per path, sent for the in_tlast beat; out_tdata[1:0] is the
//         kind (0 absolute, 1 relative, 2 unknown), upper bits zero.
// Path:    an accepted beat is held in the input register, parsed out of it
//          into the result register when it may advance, and shown on
//          out_tvalid from the result register until it is taken.
// Throughput: one character per cycle while no final character waits on a
//          stall, set by the parser update between the two registers.
// Reset: parser returns to the prefix phase, both registers empty.
// Stall: the result register holds its beat while out_tready is low. Non-final
//          characters keep flowing; a final character waits in the input
//          register until the result register frees, and in_tready then drops.

module path_kind_classifier
  import pkc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  input  logic       in_tlast,   // last_char
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [1:0] path_kind, [7:2] zero
);

  logic  st_valid_r;
  item_t st_item_r;
  logic  out_valid_r;
  kind_t out_kind_r;
  kind_t kind;
  logic  adv;

  // a final character needs a free result slot to move on
  assign adv       = st_valid_r && (!st_item_r.last_char || !out_valid_r || out_tready);
  assign in_tready = !st_valid_r || adv;

  pkc_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .item  (st_item_r),
    .kind  (kind)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else if (in_tready) begin
      st_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      st_item_r.char_code <= in_tdata;
      st_item_r.last_char <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && st_item_r.last_char) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && st_item_r.last_char) begin
      out_kind_r <= kind;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_kind_r};

`include "path_kind_classifier_macros.svh"

  `PKC_ASSERT(a_kind_code, out_valid_r |-> (out_kind_r != 2'd3), "illegal path kind")
  `PKC_ASSERT(a_final_emits, (adv && st_item_r.last_char) |=> out_valid_r, "result lost")
  `PKC_ASSERT(a_no_overwrite, (out_valid_r && !out_tready) |-> !(adv && st_item_r.last_char), "result overwritten")
  `PKC_ASSERT_ALWAYS(a_stall_full, !in_tready |-> st_valid_r, "stall with empty input register")

endmodule
